@@ sv/smm_pkg.sv @@
package smm_pkg;

    localparam int DIM    = 4;
    localparam int MAX_N  = (DIM < 4) ? DIM : 4;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;
    localparam int SIZE_W = 3;
    localparam int ADDR_W = $clog2(DIM * DIM);

    typedef struct packed {
        logic                     load_second;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] element_value;
        logic                     start_compute;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] product_value;
        logic                     last_entry;
    } out_item_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_ISSUE,
        CTL_DRAIN
    } ctl_state_t;

    // command from the sequencer to the datapath
    typedef struct packed {
        logic             wr_en;
        logic             mac_valid;
        logic             first_k;
        logic             last_k;
        logic             final_entry;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } dp_status_t;

endpackage

@@ sv/smm_ctrl.sv @@
module smm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                start_compute,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_data,
    input  smm_pkg::dp_status_t status,
    output smm_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import smm_pkg::*;

    ctl_state_t        state_reg, state_next;
    logic [SIZE_W-1:0] matrix_size_reg;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [SIZE_W-1:0] n_act;
    logic [SIZE_W-1:0] n_m1;
    logic              accept;
    logic              last_k, last_j, last_i, final_issue;

    assign n_act  = (matrix_size_reg > SIZE_W'(MAX_N)) ? SIZE_W'(MAX_N) : matrix_size_reg;
    assign n_m1   = n_act - SIZE_W'(1);
    assign accept = start && (state_reg == CTL_IDLE);

    assign last_k      = ({1'b0, k_reg} == n_m1);
    assign last_j      = ({1'b0, j_reg} == n_m1);
    assign last_i      = ({1'b0, i_reg} == n_m1);
    assign final_issue = last_i && last_j && last_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= CTL_IDLE;
            matrix_size_reg <= SIZE_W'(4);
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                matrix_size_reg <= cfg_data;
            end
        end
    end

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (accept && start_compute && (n_act != '0))
                begin
                    state_next = CTL_ISSUE;
                end
            end
            CTL_ISSUE:
            begin
                if (last_k)
                begin
                    k_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                if (final_issue)
                begin
                    state_next = CTL_DRAIN;
                end
            end
            CTL_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd             = '0;
        cmd.i           = i_reg;
        cmd.j           = j_reg;
        cmd.k           = k_reg;
        cmd.first_k     = (k_reg == '0);
        cmd.last_k      = last_k;
        cmd.final_entry = final_issue;
        busy            = 1'b1;
        case (state_reg)
            CTL_IDLE:
            begin
                busy       = 1'b0;
                cmd.wr_en  = start;
            end
            CTL_ISSUE:
            begin
                cmd.mac_valid = 1'b1;
            end
            CTL_DRAIN:
            begin
                cmd.mac_valid = 1'b0;
            end
            default:
            begin
                cmd.mac_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/smm_dp.sv @@
module smm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  smm_pkg::in_item_t   request,
    input  smm_pkg::dp_cmd_t    cmd,
    output smm_pkg::dp_status_t status,
    output smm_pkg::out_item_t  result,
    output logic                result_valid
);
    import smm_pkg::*;

    logic [DATA_W-1:0] mem_a [DIM*DIM];
    logic [DATA_W-1:0] mem_b [DIM*DIM];

    logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic              wr_in_range;

    // stage 1: operand read
    logic              v1_reg, first1_reg, last1_reg, final1_reg;
    logic [IDX_W-1:0]  row1_reg, col1_reg;
    logic [DATA_W-1:0] a_rd_reg, b_rd_reg;
    // stage 2: multiply
    logic              v2_reg, first2_reg, last2_reg, final2_reg;
    logic [IDX_W-1:0]  row2_reg, col2_reg;
    logic [DATA_W-1:0] prod_reg, prod_next;
    // stage 3: accumulate
    logic [DATA_W-1:0] acc_reg, acc_next;
    out_item_t         result_reg;
    logic              result_valid_reg;

    assign wr_in_range = (int'(request.row_index) < DIM) && (int'(request.col_index) < DIM);
    assign wr_addr   = ADDR_W'(ADDR_W'(request.row_index) * ADDR_W'(DIM)
                               + ADDR_W'(request.col_index));
    assign rd_a_addr = ADDR_W'(ADDR_W'(cmd.i) * ADDR_W'(DIM) + ADDR_W'(cmd.k));
    assign rd_b_addr = ADDR_W'(ADDR_W'(cmd.k) * ADDR_W'(DIM) + ADDR_W'(cmd.j));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            if (request.load_second)
            begin
                mem_b[wr_addr] <= request.element_value;
            end
            else
            begin
                mem_a[wr_addr] <= request.element_value;
            end
        end
        a_rd_reg <= mem_a[rd_a_addr];
        b_rd_reg <= mem_b[rd_b_addr];
    end

    // low word of the product is the same for signed and unsigned operands
    assign prod_next = a_rd_reg * b_rd_reg;
    assign acc_next  = (first2_reg ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg           <= cmd.mac_valid;
            v2_reg           <= v1_reg;
            result_valid_reg <= v2_reg && last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.first_k;
        last1_reg  <= cmd.last_k;
        final1_reg <= cmd.final_entry;
        row1_reg   <= cmd.i;
        col1_reg   <= cmd.j;

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        final2_reg <= final1_reg;
        row2_reg   <= row1_reg;
        col2_reg   <= col1_reg;
        prod_reg   <= prod_next;

        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (v2_reg && last2_reg)
        begin
            result_reg.out_row       <= row2_reg;
            result_reg.out_col       <= col2_reg;
            result_reg.product_value <= acc_next;
            result_reg.last_entry    <= final2_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign result           = result_reg;
    assign result_valid     = result_valid_reg;

endmodule

@@ sv/square_matrix_multiply.sv @@
// an item that only loads an element leaves busy low
// a compute item holds busy high until every multiply-accumulate has issued and the pipeline
// has drained, one multiply-accumulate per cycle through a shared read/multiply/add pipeline
// a compute item at size zero only stores its element and leaves busy low
// entries come out in row-major order, one per position of the n x n result (n = active size)
// reset clears the sequencer and sets the size to 4; matrix contents are not cleared
// results are strobed for one cycle on result_valid with no backpressure
module square_matrix_multiply (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  smm_pkg::in_item_t  request,
    output smm_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_data
);
    import smm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    smm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .start_compute (request.start_compute),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    smm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ tb/tb_square_matrix_multiply.sv @@
`timescale 1ns / 1ps

module tb_square_matrix_multiply;
    import smm_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int TOTAL_ITEMS    = 350;
    localparam int CALM_ITEMS     = 290;
    localparam int SETTLE_CYCLES  = MAX_N * MAX_N * MAX_N + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    localparam logic [DATA_W-1:0] MAX_VAL = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    in_item_t          request  = '0;
    out_item_t         result;
    logic              result_valid;
    logic              cfg_we   = 1'b0;
    logic [SIZE_W-1:0] cfg_data = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    square_matrix_multiply u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // driver: feeds element loads from the queue, with random gaps
    // ------------------------------------------------------------------
    in_item_t load_queue[$];
    int       gap_left   = 0;
    int       gap_chance = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // move on when nothing is offered or the offered item is taken
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (load_queue.size() > 0)
                begin
                    start   <= 1'b1;
                    request <= load_queue.pop_front();
                    if ($urandom_range(1, 100) <= gap_chance)
                        gap_left = $urandom_range(1, 5);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // product predictor and checker
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] mat_a [DIM*DIM];
    logic [DATA_W-1:0] mat_b [DIM*DIM];
    logic [SIZE_W-1:0] size_reg = 3'd4;
    out_item_t         expected_products[$];
    int                error_count  = 0;
    int                quiet_cycles = 0;

    function automatic void predict_products(input in_item_t item);
        int unsigned       n;
        logic [DATA_W-1:0] acc;
        out_item_t         entry;
        int                i;
        int                j;
        int                k;
        if (item.row_index < DIM && item.col_index < DIM)
        begin
            if (item.load_second == SEL_B)
                mat_b[item.row_index * DIM + item.col_index] = item.element_value;
            else
                mat_a[item.row_index * DIM + item.col_index] = item.element_value;
        end
        if (!item.start_compute)
            return;
        n = (size_reg > MAX_N) ? MAX_N : size_reg;
        for (i = 0; i < n; i++)
        begin
            for (j = 0; j < n; j++)
            begin
                acc = '0;
                for (k = 0; k < n; k++)
                    acc = acc + mat_a[i * DIM + k] * mat_b[k * DIM + j];
                entry.out_row       = IDX_W'(i);
                entry.out_col       = IDX_W'(j);
                entry.product_value = acc;
                entry.last_entry    = (i == n - 1 && j == n - 1);
                expected_products.push_back(entry);
            end
        end
    endfunction

    function automatic void report_field(input string field,
                                         input logic signed [DATA_W-1:0] want_v,
                                         input logic signed [DATA_W-1:0] got_v);
        $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        error_count++;
    endfunction

    function automatic void check_product(input out_item_t got);
        out_item_t want;
        if (expected_products.size() == 0)
        begin
            $display("%0t: product entry expected none actual row %0d col %0d value %0d",
                     $time, got.out_row, got.out_col, got.product_value);
            error_count++;
            return;
        end
        want = expected_products.pop_front();
        if (got.out_row !== want.out_row)
            report_field("out_row", want.out_row, got.out_row);
        if (got.out_col !== want.out_col)
            report_field("out_col", want.out_col, got.out_col);
        if (got.product_value !== want.product_value)
            report_field("product_value", want.product_value, got.product_value);
        if (got.last_entry !== want.last_entry)
            report_field("last_entry", want.last_entry, got.last_entry);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            size_reg = 3'd4;
        end
        else
        begin
            if (result_valid)
                check_product(result);
            if (cfg_we)
                size_reg = cfg_data;
            if (start && !busy)
                predict_products(request);
            if ((start && !busy) || result_valid)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [DIM*DIM-1:0] loaded_a  = '0;
    logic [DIM*DIM-1:0] loaded_b  = '0;
    int unsigned        gen_n     = MAX_N;
    int                 items_made = 0;

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return MAX_VAL;
            1:       return MIN_VAL;
            2:       return '0;
            3:       return '1;
            4:       return DATA_W'($urandom_range(0, 20) - 10);
            default: return $urandom;
        endcase
    endfunction

    // a compute request is only kept once every active entry has been loaded
    function automatic void push_load(input logic sel, input int r, input int c,
                                      input logic [DATA_W-1:0] v, input bit want_go);
        in_item_t item;
        bit       ready;
        int       i;
        int       j;
        if (sel == SEL_B)
            loaded_b[r * DIM + c] = 1'b1;
        else
            loaded_a[r * DIM + c] = 1'b1;
        ready = 1'b1;
        for (i = 0; i < gen_n; i++)
            for (j = 0; j < gen_n; j++)
                if (!loaded_a[i * DIM + j] || !loaded_b[i * DIM + j])
                    ready = 1'b0;
        item.load_second   = sel;
        item.row_index     = IDX_W'(r);
        item.col_index     = IDX_W'(c);
        item.element_value = v;
        item.start_compute = want_go && ready;
        load_queue.push_back(item);
        items_made++;
    endfunction

    function automatic void push_random_load(input bit want_go);
        push_load(logic'($urandom_range(0, 1)), $urandom_range(0, DIM - 1),
                  $urandom_range(0, DIM - 1), pick_value(), want_go);
    endfunction

    // both active matrices in shuffled order, compute on the last element; at size zero, one random load with compute
    function automatic void load_full_set();
        int order [2*DIM*DIM];
        int cnt;
        int s;
        int t;
        int tmp;
        int i;
        int j;
        if (gen_n == 0)
        begin
            push_random_load(1'b1);
            return;
        end
        cnt = 0;
        for (s = 0; s < 2; s++)
            for (i = 0; i < gen_n; i++)
                for (j = 0; j < gen_n; j++)
                begin
                    order[cnt] = (s * DIM + i) * DIM + j;
                    cnt++;
                end
        for (s = cnt - 1; s > 0; s--)
        begin
            t        = $urandom_range(0, s);
            tmp      = order[s];
            order[s] = order[t];
            order[t] = tmp;
        end
        for (s = 0; s < cnt; s++)
            push_load(logic'(order[s] / (DIM * DIM)), (order[s] / DIM) % DIM,
                      order[s] % DIM, pick_value(), s == cnt - 1);
    endfunction

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (load_queue.size() != 0 || start || busy || expected_products.size() != 0);
        // a size-zero compute leaves no result behind, so let the block drain
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int v);
        wait_quiet();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= SIZE_W'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
        gen_n = (v > MAX_N) ? MAX_N : v;
    endtask

    initial
    begin
        int phase;
        int v;
        int kind;
        int m;
        int s;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // single entries at the value extremes
        set_size(1);
        push_load(SEL_A, 0, 0, MAX_VAL, 1'b0);
        push_load(SEL_B, 0, 0, MIN_VAL, 1'b1);
        push_load(SEL_B, 0, 0, MAX_VAL, 1'b1);

        // 2x2 with wrapping sums
        set_size(2);
        push_load(SEL_A, 0, 0, '1, 1'b0);
        push_load(SEL_A, 0, 1, MIN_VAL, 1'b0);
        push_load(SEL_A, 1, 0, MAX_VAL, 1'b0);
        push_load(SEL_A, 1, 1, 32'd1, 1'b0);
        push_load(SEL_B, 0, 0, MIN_VAL, 1'b0);
        push_load(SEL_B, 0, 1, '1, 1'b0);
        push_load(SEL_B, 1, 0, 32'd2, 1'b0);
        push_load(SEL_B, 1, 1, MAX_VAL, 1'b1);
        push_load(SEL_A, 3, 3, 32'h5555_5555, 1'b0);

        // size zero: compute request stores but emits nothing
        set_size(0);
        push_load(SEL_B, 3, 3, 32'haaaa_aaaa, 1'b1);
        push_load(SEL_A, 2, 1, 32'd1, 1'b1);

        phase = 0;
        while (items_made < TOTAL_ITEMS)
        begin
            case (phase)
                0:       v = 4;
                1:       v = 7;
                2:       v = 3;
                3:       v = 6;
                4:       v = 5;
                5:       v = 1;
                6:       v = 0;
                7:       v = 2;
                default: v = $urandom_range(0, 7);
            endcase
            if (items_made >= CALM_ITEMS)
                gap_chance = 0;
            else
                gap_chance = $urandom_range(0, 3) * 15;
            set_size(v);
            repeat ($urandom_range(1, 4))
            begin
                kind = $urandom_range(0, 9);
                m    = $urandom_range(1, 6);
                if (items_made >= TOTAL_ITEMS)
                begin
                    // enough items queued for this run
                end
                else if (kind <= 6)
                begin
                    load_full_set();
                end
                else if (kind == 7)
                begin
                    // partial update, then recompute
                    for (s = 0; s < m; s++)
                        push_random_load(s == m - 1);
                end
                else if (kind == 8)
                begin
                    for (s = 0; s < m; s++)
                        push_random_load(1'b0);
                end
                else
                begin
                    // compute requests scattered among loads
                    for (s = 0; s < m; s++)
                        push_random_load($urandom_range(0, 2) == 0);
                end
            end
            phase++;
        end

        wait_quiet();
        if (error_count == 0 && expected_products.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
sv/smm_pkg.sv
sv/smm_ctrl.sv
sv/smm_dp.sv
sv/square_matrix_multiply.sv
tb/tb_square_matrix_multiply.sv
